>>> hdl/pvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Polyhedron volume and centroid: shared package
// Widths of the datapath, result status codes and the record that the
// divider hands back to the sequencer.
// ----------------------------------------------------------------------------
package pvc_pkg;

   // Datapath widths.
   localparam int CoordW  = 12;   // one vertex coordinate
   localparam int CSumW   = 14;   // sum of three coordinates
   localparam int CrossW  = 25;   // one component of p x q
   localparam int VolW    = 37;   // triple product of one triangle
   localparam int MulAW   = 37;   // wide operand of the shared multiplier
   localparam int MulBW   = 14;   // narrow operand of the shared multiplier
   localparam int ProdW   = MulAW + MulBW;
   localparam int VolSumW = 49;   // running volume sum
   localparam int WSumW   = 64;   // running weighted sums
   localparam int CenW    = 16;   // one centroid axis

   // Result status codes.
   typedef logic [1:0] status_type;
   localparam status_type StOk   = 2'd0;
   localparam status_type StZero = 2'd1;
   localparam status_type StSat  = 2'd2;
   localparam status_type StOver = 2'd3;

   // Result of one division, valid for the cycle in which done is high.
   typedef struct packed {
      logic                   done;
      logic                   sat;
      logic signed [CenW-1:0] quot;
   } div_rsp_type;

endpackage
`default_nettype wire

>>> hdl/pvc_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Polyhedron volume and centroid: shared multiplier
// One signed 37 x 14 multiplier with a registered product. Every product of
// the per-triangle arithmetic goes through it in turn.
// ----------------------------------------------------------------------------
module pvc_mul (
   input  wire logic                              clock,
   input  wire logic signed [pvc_pkg::MulAW-1:0]  opa,
   input  wire logic signed [pvc_pkg::MulBW-1:0]  opb,
   output logic signed [pvc_pkg::ProdW-1:0]       prod
);

   logic signed [pvc_pkg::ProdW-1:0] prod_ff;
   logic signed [pvc_pkg::ProdW-1:0] prod_in;

   // Full-width signed product.
   always_comb begin
      prod_in = pvc_pkg::ProdW'(opa) * pvc_pkg::ProdW'(opb);
   end

   // Register after the multiplier.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

>>> hdl/pvc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Polyhedron volume and centroid: rounding divider
// Restoring divider, one quotient bit a cycle, that forms
// round(weighted_sum / (4 * volume_sum)) with ties away from zero and clamps
// the result to 16 signed bits. Quotients of 2^17 or more are caught by one
// compare up front, so only seventeen quotient bits are ever developed.
// ----------------------------------------------------------------------------
module pvc_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [pvc_pkg::WSumW-1:0]    dividend,
   input  wire logic signed [pvc_pkg::VolSumW-1:0]  divisor,
   output pvc_pkg::div_rsp_type                     result
);

   localparam int QW    = 17;
   localparam int DW    = pvc_pkg::VolSumW + 2;
   localparam int DshW  = DW + QW;
   localparam int RemW  = pvc_pkg::WSumW;
   localparam int CntW  = $clog2(QW);

   typedef enum logic [3:0] {
      D_IDLE  = 4'b0001,
      D_CHECK = 4'b0010,
      D_ITER  = 4'b0100,
      D_FIN   = 4'b1000
   } dstate_type;

   dstate_type           state_ff, state_in;
   logic [RemW-1:0]      rem_ff, rem_in;
   logic [DshW-1:0]      dsh_ff, dsh_in;
   logic [QW-1:0]        quo_ff, quo_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic                 big_ff, big_in;
   logic                 neg_ff, neg_in;
   pvc_pkg::div_rsp_type rsp_ff, rsp_in;

   logic [RemW-1:0]             wmag;
   logic [pvc_pkg::VolSumW-1:0] vmag;
   logic                        ge;
   logic [DshW-1:0]             diff;
   logic                        over;

   // Magnitudes of the operands; the rounded numerator |w| + 2|v| is formed on start.
   always_comb begin
      wmag = dividend[RemW-1] ? RemW'(-dividend) : RemW'(dividend);
      vmag = divisor[pvc_pkg::VolSumW-1] ? pvc_pkg::VolSumW'(-divisor)
                                         : pvc_pkg::VolSumW'(divisor);
   end

   // The subtractor and compare shared by the check and the iterations.
   always_comb begin
      diff = DshW'(rem_ff) - dsh_ff;
      ge   = DshW'(rem_ff) >= dsh_ff;
   end

   // Saturation test on the finished quotient.
   always_comb begin
      if (neg_ff) begin
         over = big_ff || (quo_ff > QW'(32768));
      end else begin
         over = big_ff || (quo_ff > QW'(32767));
      end
   end

   // Sequencer of the division.
   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      big_in   = big_ff;
      neg_in   = neg_ff;
      rsp_in   = '0;
      rsp_in.quot = rsp_ff.quot;
      rsp_in.sat  = rsp_ff.sat;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               rem_in   = wmag + RemW'({vmag, 1'b0});
               dsh_in   = {vmag, 2'b00, {QW{1'b0}}};
               neg_in   = dividend[RemW-1] ^ divisor[pvc_pkg::VolSumW-1];
               quo_in   = '0;
               state_in = D_CHECK;
            end
         end
         D_CHECK: begin
            big_in   = ge;
            dsh_in   = dsh_ff >> 1;
            cnt_in   = '0;
            state_in = D_ITER;
         end
         D_ITER: begin
            if (ge) begin
               rem_in = diff[RemW-1:0];
            end
            quo_in = {quo_ff[QW-2:0], ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(QW - 1)) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            rsp_in.done = 1'b1;
            rsp_in.sat  = over;
            if (neg_ff) begin
               rsp_in.quot = over ? pvc_pkg::CenW'(-32768)
                                  : pvc_pkg::CenW'(QW'(0) - quo_ff);
            end else begin
               rsp_in.quot = over ? pvc_pkg::CenW'(32767)
                                  : pvc_pkg::CenW'(quo_ff);
            end
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   // Control state is reset; the datapath is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= D_IDLE;
         rsp_ff.done <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rsp_ff.done <= rsp_in.done;
      end
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      big_ff      <= big_in;
      neg_ff      <= neg_in;
      rsp_ff.sat  <= rsp_in.sat;
      rsp_ff.quot <= rsp_in.quot;
   end

   assign result = rsp_ff;

endmodule
`default_nettype wire

>>> hdl/polyhedron_volume_centroid_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Polyhedron volume and centroid: top level
// Accumulates signed tetrahedron volumes of a closed triangle mesh and, on
// the last triangle, returns the enclosed-volume centroid and six times the
// enclosed volume.
// ----------------------------------------------------------------------------
// A triangle is taken when start is high while busy is low. Each triangle
// that is held keeps busy high while its twelve products go in turn through
// a single shared 37 x 14 multiplier, with a pipeline fill and a pause in
// which the triple product settles before it is multiplied by the coordinate
// sums. A triangle that arrives once MAX_TRIANGLES are held is dropped and
// does not raise busy unless it is marked last, in which case it holds busy
// for the check and the result load. On the triangle marked last, a check
// follows and then, unless the volume is zero or triangles were dropped,
// three divisions in the bit-serial divider, one per axis, and the result
// load, with busy high throughout. The result appears for exactly one cycle
// with rsp_strobe high, in the first cycle in which busy is low, and the
// receiver cannot hold it off; the sums are already clear in that cycle, and
// a new request can be taken in it.
// ----------------------------------------------------------------------------
module polyhedron_volume_centroid_top #(
   parameter int MAX_TRIANGLES = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic signed [pvc_pkg::CoordW-1:0]    req_p_x,
   input  wire logic signed [pvc_pkg::CoordW-1:0]    req_p_y,
   input  wire logic signed [pvc_pkg::CoordW-1:0]    req_p_z,
   input  wire logic signed [pvc_pkg::CoordW-1:0]    req_q_x,
   input  wire logic signed [pvc_pkg::CoordW-1:0]    req_q_y,
   input  wire logic signed [pvc_pkg::CoordW-1:0]    req_q_z,
   input  wire logic signed [pvc_pkg::CoordW-1:0]    req_r_x,
   input  wire logic signed [pvc_pkg::CoordW-1:0]    req_r_y,
   input  wire logic signed [pvc_pkg::CoordW-1:0]    req_r_z,
   input  wire logic                                 req_last_triangle,
   output logic                                      rsp_strobe,
   output logic signed [pvc_pkg::CenW-1:0]           rsp_centroid_x,
   output logic signed [pvc_pkg::CenW-1:0]           rsp_centroid_y,
   output logic signed [pvc_pkg::CenW-1:0]           rsp_centroid_z,
   output logic signed [pvc_pkg::VolSumW-1:0]        rsp_six_volume_total,
   output pvc_pkg::status_type                       rsp_status
);

   localparam int CntW  = $clog2(MAX_TRIANGLES + 2);
   localparam int StepW = 4;
   localparam logic [StepW-1:0] LastStep = StepW'(13);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MUL   = 6'b000010,
      S_CHK   = 6'b000100,
      S_DIV   = 6'b001000,
      S_DWAIT = 6'b010000,
      S_FIN   = 6'b100000
   } state_type;

   state_type                              state_ff, state_in;
   logic [StepW-1:0]                       step_ff, step_in;
   logic [1:0]                             axis_ff, axis_in;
   logic [CntW-1:0]                        cnt_ff, cnt_in;

   // Captured triangle.
   logic signed [pvc_pkg::CoordW-1:0]      px_ff, py_ff, pz_ff;
   logic signed [pvc_pkg::CoordW-1:0]      qx_ff, qy_ff, qz_ff;
   logic signed [pvc_pkg::CoordW-1:0]      rx_ff, ry_ff, rz_ff;
   logic signed [pvc_pkg::CSumW-1:0]       sx_ff, sy_ff, sz_ff;
   logic                                   last_ff;

   // Intermediate and running sums.
   logic signed [pvc_pkg::CrossW-1:0]      cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [pvc_pkg::VolW-1:0]        v_ff, v_in;
   logic signed [pvc_pkg::VolSumW-1:0]     vol_ff, vol_in;
   logic signed [pvc_pkg::WSumW-1:0]       wx_ff, wx_in, wy_ff, wy_in, wz_ff, wz_in;

   // Centroid collection and the result register.
   logic signed [pvc_pkg::CenW-1:0]        cen_ff [3];
   logic                                   sat_ff, sat_in;
   logic                                   strobe_ff, strobe_in;
   logic signed [pvc_pkg::CenW-1:0]        ocx_ff, ocy_ff, ocz_ff;
   logic signed [pvc_pkg::VolSumW-1:0]     ovol_ff;
   pvc_pkg::status_type                    ost_ff, ost_in;

   // Shared multiplier and divider connections.
   logic signed [pvc_pkg::MulAW-1:0]       opa;
   logic signed [pvc_pkg::MulBW-1:0]       opb;
   logic signed [pvc_pkg::ProdW-1:0]       prod;
   logic signed [pvc_pkg::WSumW-1:0]       div_num;
   logic                                   div_start;
   pvc_pkg::div_rsp_type                   div_rsp;

   logic                                   accept;
   logic                                   dropped;
   logic                                   vol_zero;

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && (state_ff == S_IDLE);
   assign dropped  = cnt_ff > CntW'(MAX_TRIANGLES);
   assign vol_zero = (vol_ff == '0);

   // Operand selection for the shared multiplier, at most one product a step.
   always_comb begin
      opa = '0;
      opb = '0;
      case (step_ff)
         4'd0:  begin opa = pvc_pkg::MulAW'(py_ff); opb = pvc_pkg::MulBW'(qz_ff); end
         4'd1:  begin opa = pvc_pkg::MulAW'(pz_ff); opb = pvc_pkg::MulBW'(qy_ff); end
         4'd2:  begin opa = pvc_pkg::MulAW'(pz_ff); opb = pvc_pkg::MulBW'(qx_ff); end
         4'd3:  begin opa = pvc_pkg::MulAW'(px_ff); opb = pvc_pkg::MulBW'(qz_ff); end
         4'd4:  begin opa = pvc_pkg::MulAW'(px_ff); opb = pvc_pkg::MulBW'(qy_ff); end
         4'd5:  begin opa = pvc_pkg::MulAW'(py_ff); opb = pvc_pkg::MulBW'(qx_ff); end
         4'd6:  begin opa = pvc_pkg::MulAW'(cx_ff); opb = pvc_pkg::MulBW'(rx_ff); end
         4'd7:  begin opa = pvc_pkg::MulAW'(cy_ff); opb = pvc_pkg::MulBW'(ry_ff); end
         4'd8:  begin opa = pvc_pkg::MulAW'(cz_ff); opb = pvc_pkg::MulBW'(rz_ff); end
         4'd10: begin opa = v_ff; opb = sx_ff; end
         4'd11: begin opa = v_ff; opb = sy_ff; end
         4'd12: begin opa = v_ff; opb = sz_ff; end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   pvc_mul u_mul (
      .clock (clock),
      .opa   (opa),
      .opb   (opb),
      .prod  (prod)
   );

   // Weighted sum handed to the divider for the current axis.
   always_comb begin
      case (axis_ff)
         2'd0:    div_num = wx_ff;
         2'd1:    div_num = wy_ff;
         default: div_num = wz_ff;
      endcase
   end

   assign div_start = (state_ff == S_DIV);

   pvc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (vol_ff),
      .result   (div_rsp)
   );

   // Result status by priority: dropped triangles, zero volume, saturation.
   always_comb begin
      if (dropped) begin
         ost_in = pvc_pkg::StOver;
      end else if (vol_zero) begin
         ost_in = pvc_pkg::StZero;
      end else if (sat_ff) begin
         ost_in = pvc_pkg::StSat;
      end else begin
         ost_in = pvc_pkg::StOk;
      end
   end

   // Sequencer: accumulate each triangle, divide on the last one.
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      axis_in   = axis_ff;
      cnt_in    = cnt_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      cz_in     = cz_ff;
      v_in      = v_ff;
      vol_in    = vol_ff;
      wx_in     = wx_ff;
      wy_in     = wy_ff;
      wz_in     = wz_ff;
      sat_in    = sat_ff;
      strobe_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (cnt_ff < CntW'(MAX_TRIANGLES)) begin
                  step_in  = '0;
                  state_in = S_MUL;
               end else begin
                  cnt_in = CntW'(MAX_TRIANGLES + 1);
                  if (req_last_triangle) begin
                     state_in = S_CHK;
                  end
               end
            end
         end
         S_MUL: begin
            // Each step takes up the product issued in the step before.
            case (step_ff)
               4'd1:  cx_in = pvc_pkg::CrossW'(prod);
               4'd2:  cx_in = cx_ff - pvc_pkg::CrossW'(prod);
               4'd3:  cy_in = pvc_pkg::CrossW'(prod);
               4'd4:  cy_in = cy_ff - pvc_pkg::CrossW'(prod);
               4'd5:  cz_in = pvc_pkg::CrossW'(prod);
               4'd6:  cz_in = cz_ff - pvc_pkg::CrossW'(prod);
               4'd7:  v_in  = pvc_pkg::VolW'(prod);
               4'd8:  v_in  = v_ff + pvc_pkg::VolW'(prod);
               4'd9:  v_in  = v_ff + pvc_pkg::VolW'(prod);
               4'd11: begin
                  wx_in  = wx_ff + pvc_pkg::WSumW'(prod);
                  vol_in = vol_ff + pvc_pkg::VolSumW'(v_ff);
               end
               4'd12: wy_in = wy_ff + pvc_pkg::WSumW'(prod);
               4'd13: wz_in = wz_ff + pvc_pkg::WSumW'(prod);
               default: begin
                  v_in = v_ff;
               end
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff == LastStep) begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = last_ff ? S_CHK : S_IDLE;
            end
         end
         S_CHK: begin
            axis_in = '0;
            sat_in  = 1'b0;
            if (dropped || vol_zero) begin
               state_in = S_FIN;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_rsp.done) begin
               sat_in = sat_ff | div_rsp.sat;
               if (axis_ff == 2'd2) begin
                  state_in = S_FIN;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_FIN: begin
            strobe_in = 1'b1;
            cnt_in    = '0;
            vol_in    = '0;
            wx_in     = '0;
            wy_in     = '0;
            wz_in     = '0;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The state, the triangle count, the running sums and the strobe are reset; the rest is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         vol_ff    <= '0;
         wx_ff     <= '0;
         wy_ff     <= '0;
         wz_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         vol_ff    <= vol_in;
         wx_ff     <= wx_in;
         wy_ff     <= wy_in;
         wz_ff     <= wz_in;
         strobe_ff <= strobe_in;
      end
      step_ff <= step_in;
      axis_ff <= axis_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      v_ff    <= v_in;
      sat_ff  <= sat_in;
   end

   // Capture the triangle and its coordinate sums on acceptance.
   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff   <= req_p_x;
         py_ff   <= req_p_y;
         pz_ff   <= req_p_z;
         qx_ff   <= req_q_x;
         qy_ff   <= req_q_y;
         qz_ff   <= req_q_z;
         rx_ff   <= req_r_x;
         ry_ff   <= req_r_y;
         rz_ff   <= req_r_z;
         sx_ff   <= pvc_pkg::CSumW'(req_p_x) + pvc_pkg::CSumW'(req_q_x)
                    + pvc_pkg::CSumW'(req_r_x);
         sy_ff   <= pvc_pkg::CSumW'(req_p_y) + pvc_pkg::CSumW'(req_q_y)
                    + pvc_pkg::CSumW'(req_r_y);
         sz_ff   <= pvc_pkg::CSumW'(req_p_z) + pvc_pkg::CSumW'(req_q_z)
                    + pvc_pkg::CSumW'(req_r_z);
         last_ff <= req_last_triangle;
      end
   end

   // Collect each centroid axis as the divider finishes it.
   always_ff @(posedge clock) begin
      if ((state_ff == S_DWAIT) && div_rsp.done) begin
         cen_ff[axis_ff] <= div_rsp.quot;
      end
   end

   // Result register, loaded in the final cycle of the mesh.
   always_ff @(posedge clock) begin
      if (state_ff == S_FIN) begin
         ost_ff  <= ost_in;
         ovol_ff <= vol_ff;
         if (dropped || vol_zero) begin
            ocx_ff <= '0;
            ocy_ff <= '0;
            ocz_ff <= '0;
         end else begin
            ocx_ff <= cen_ff[0];
            ocy_ff <= cen_ff[1];
            ocz_ff <= cen_ff[2];
         end
      end
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_centroid_x       = ocx_ff;
   assign rsp_centroid_y       = ocy_ff;
   assign rsp_centroid_z       = ocz_ff;
   assign rsp_six_volume_total = ovol_ff;
   assign rsp_status           = ost_ff;

endmodule
`default_nettype wire
